// ===== hdl/can_receive_timeout_breaker_macros.svh =====
// Assertion macros used by the port-level checker of the receive timeout breaker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CAN_RECEIVE_TIMEOUT_BREAKER_MACROS_SVH
`define CAN_RECEIVE_TIMEOUT_BREAKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CANTB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cantb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CANTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cantb assertion failed");

`endif

// ===== hdl/cantb_pkg.sv =====
// Shared constants and widths for the CAN receive timeout breaker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cantb_pkg;

	localparam int SlotsDef = 4;
	localparam int SlotsMax = 4;

	localparam int IdW      = 11;
	localparam int SlotIdW  = 12;
	localparam int AgeW     = 16;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 64;
	localparam int PayloadW = 64;
	localparam int LenW     = 4;
	localparam int InDataW  = 16;
	localparam int OutDataW = 80;

	// Item kinds carried on the input user field.
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] CFG_SLOT_A       = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT      = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_PERIOD       = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_EXIT_FIRST   = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_EXIT_SECOND  = 3'd7;

	localparam logic [SlotIdW-1:0] ID_UNUSED     = 12'h800;
	localparam logic [AgeW-1:0]    AGE_MAX       = 16'hFFFF;
	localparam logic [AgeW-1:0]    TIMEOUT_RST   = 16'd50;
	localparam logic [AgeW-1:0]    PERIOD_RST    = 16'd10;
	localparam logic [IdW-1:0]     TX_ID_FIRST   = 11'h200;
	localparam logic [IdW-1:0]     TX_ID_SECOND  = 11'h1FF;
	localparam logic [LenW-1:0]    FRAME_LEN     = 4'd8;

endpackage

// ===== hdl/cantb_core.sv =====
// Slot table, check timer and configuration registers of the timeout breaker.
// Depends on cantb_pkg; signals a trip to the transmit stage.
`timescale 1ns / 1ps

module cantb_core #(
	parameter int SLOTS = cantb_pkg::SlotsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  logic [cantb_pkg::IdW-1:0]     in_id,
	input  logic                          cfg_we,
	input  logic [cantb_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [cantb_pkg::CfgDataW-1:0] cfg_wdata,
	input  logic                          tx_free,
	output logic                          fire,
	output logic [cantb_pkg::PayloadW-1:0] payload_first,
	output logic [cantb_pkg::PayloadW-1:0] payload_second
);

	logic                          valid_s1;
	logic                          op_s1;
	logic [cantb_pkg::IdW-1:0]     id_s1;
	logic [cantb_pkg::AgeW-1:0]    timeout_q;
	logic [cantb_pkg::AgeW-1:0]    period_q;
	logic [cantb_pkg::AgeW-1:0]    period_count_q;
	logic [cantb_pkg::PayloadW-1:0] exit_first_q;
	logic [cantb_pkg::PayloadW-1:0] exit_second_q;

	logic                          go;
	logic                          tick_go;
	logic                          check;
	logic [cantb_pkg::AgeW-1:0]    period_eff;
	logic [SLOTS-1:0]              trip_new;

	// The item in the input register is retired once the transmit stage can take a trip.
	assign go       = valid_s1 && tx_free;
	assign tick_go  = go && (op_s1 == cantb_pkg::OP_TICK);
	assign in_ready = !valid_s1 || tx_free;

	assign period_eff = (period_q == '0) ? cantb_pkg::AgeW'(1) : period_q;
	assign check      = ({1'b0, period_count_q} + 17'd1) >= {1'b0, period_eff};
	assign fire       = tick_go && check && (|trip_new);

	assign payload_first  = exit_first_q;
	assign payload_second = exit_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= in_op;
			id_s1 <= in_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q      <= cantb_pkg::TIMEOUT_RST;
			period_q       <= cantb_pkg::PERIOD_RST;
			exit_first_q   <= '0;
			exit_second_q  <= '0;
			period_count_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					cantb_pkg::CFG_TIMEOUT: begin
						timeout_q <= cfg_wdata[cantb_pkg::AgeW-1:0];
					end
					cantb_pkg::CFG_PERIOD: begin
						period_q <= cfg_wdata[cantb_pkg::AgeW-1:0];
					end
					cantb_pkg::CFG_EXIT_FIRST: begin
						exit_first_q <= cfg_wdata;
					end
					cantb_pkg::CFG_EXIT_SECOND: begin
						exit_second_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (tick_go) begin
				period_count_q <= check ? '0 : period_count_q + cantb_pkg::AgeW'(1);
			end
		end
	end

	for (genvar k = 0; k < SLOTS; k++) begin : g_slot
		logic [cantb_pkg::SlotIdW-1:0] slot_id_q;
		logic [cantb_pkg::AgeW-1:0]    age_q;
		logic                          tripped_q;
		logic                          used;
		logic                          hit;
		logic                          cfg_hit;
		logic [cantb_pkg::AgeW-1:0]    age_next;

		// An identifier with the top bit set marks the slot unused.
		assign used     = !slot_id_q[cantb_pkg::SlotIdW-1];
		assign hit      = used && (slot_id_q[cantb_pkg::IdW-1:0] == id_s1);
		assign cfg_hit  = cfg_we &&
			(cfg_idx == cantb_pkg::CFG_SLOT_A + cantb_pkg::CfgIdxW'(k));
		assign age_next = (used && age_q != cantb_pkg::AGE_MAX) ?
			age_q + cantb_pkg::AgeW'(1) : age_q;
		assign trip_new[k] = used && !tripped_q && (age_next > timeout_q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slot_id_q <= cantb_pkg::ID_UNUSED;
				age_q     <= '0;
				tripped_q <= 1'b0;
			end else if (cfg_hit) begin
				slot_id_q <= cfg_wdata[cantb_pkg::SlotIdW-1:0];
				age_q     <= '0;
				tripped_q <= 1'b0;
			end else if (go) begin
				if (op_s1 == cantb_pkg::OP_FRAME) begin
					if (hit) begin
						age_q     <= '0;
						tripped_q <= 1'b0;
					end
				end else begin
					age_q <= age_next;
					if (check && trip_new[k]) begin
						tripped_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/cantb_tx.sv =====
// Output register that sends the pair of shutdown frames after a trip.
// Depends on cantb_pkg; fed by cantb_core.
`timescale 1ns / 1ps

module cantb_tx (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	output logic                            tx_free,
	input  logic [cantb_pkg::PayloadW-1:0]  payload_first,
	input  logic [cantb_pkg::PayloadW-1:0]  payload_second,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cantb_pkg::OutDataW-1:0]  m_tdata,
	output logic                            m_tlast
);

	logic valid_q;
	logic second_q;
	logic [cantb_pkg::IdW-1:0]      tx_id;
	logic [cantb_pkg::PayloadW-1:0] tx_payload;

	// Room for a new pair exists once the second frame of the current pair leaves.
	assign tx_free = !valid_q || (m_tready && second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (fire) begin
			valid_q  <= 1'b1;
			second_q <= 1'b0;
		end else if (valid_q && m_tready) begin
			valid_q  <= !second_q;
			second_q <= !second_q;
		end
	end

	assign tx_id      = second_q ? cantb_pkg::TX_ID_SECOND : cantb_pkg::TX_ID_FIRST;
	assign tx_payload = second_q ? payload_second : payload_first;

	assign m_tvalid = valid_q;
	assign m_tlast  = second_q;
	assign m_tdata  = {1'b0, cantb_pkg::FRAME_LEN, tx_payload, tx_id};

endmodule

// ===== hdl/can_receive_timeout_breaker.sv =====
// CAN receive timeout breaker: watches up to SLOTS identifiers and sends a shutdown pair on timeout.
// Timing: an item is registered, then retired once the transmit stage is free; a trip shows its first frame
// in the cycle after that. Throughput: one item per cycle while the transmit stage is free; a trip holds
// new items until the single output register has sent the two shutdown frames one after the other.
// Reset (arst_n low, asynchronous): slots unused, ages, trips and check counter cleared,
// timeout 50, check period 10, exit payloads zero.
`timescale 1ns / 1ps

module can_receive_timeout_breaker #(
	parameter int SLOTS = cantb_pkg::SlotsDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input requests: received frames and time ticks.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [cantb_pkg::InDataW-1:0]    s_axis_tdata,  // [10:0] rx_id, [15:11] zero
	input  logic                             s_axis_tuser,  // [0] op: 0 frame, 1 tick
	// Output requests: shutdown frames.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [cantb_pkg::OutDataW-1:0]   m_axis_tdata,  // [10:0] tx_id, [74:11] tx_payload,
	                                                        // [78:75] tx_length, [79] zero
	output logic                             m_axis_tlast,  // last frame of the pair
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cantb_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [cantb_pkg::CfgDataW-1:0]   cfg_data
);

	logic                            fire;
	logic                            tx_free;
	logic [cantb_pkg::PayloadW-1:0]  payload_first;
	logic [cantb_pkg::PayloadW-1:0]  payload_second;

	// Registers are plain flops and accept a write in every cycle.
	assign cfg_ready = 1'b1;

	// The core holds the slot table and decides, per tick, whether any slot newly trips.
	cantb_core #(
		.SLOTS(SLOTS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_op          (s_axis_tuser),
		.in_id          (s_axis_tdata[cantb_pkg::IdW-1:0]),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_idx        (cfg_index),
		.cfg_wdata      (cfg_data),
		.tx_free        (tx_free),
		.fire           (fire),
		.payload_first  (payload_first),
		.payload_second (payload_second)
	);

	// The transmit stage turns one trip into the two shutdown frames.
	cantb_tx u_tx (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.tx_free        (tx_free),
		.payload_first  (payload_first),
		.payload_second (payload_second),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.m_tlast        (m_axis_tlast)
	);

endmodule

// ===== hdl/cantb_chk.sv =====
// Port-level checker for the CAN receive timeout breaker, bound to the top level.
// Depends on cantb_pkg and can_receive_timeout_breaker_macros.svh.
`timescale 1ns / 1ps
`include "can_receive_timeout_breaker_macros.svh"

module cantb_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [cantb_pkg::OutDataW-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	// A stalled frame stays offered.
	`CANTB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// A first frame that is taken is always followed by the second frame of its pair.
	`CANTB_ASSERT_NEXT(a_pair, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast)

	// The frame identifier follows the position in the pair.
	`CANTB_ASSERT_NOW(a_id, m_axis_tvalid, m_axis_tdata[10:0] == (m_axis_tlast ? cantb_pkg::TX_ID_SECOND : cantb_pkg::TX_ID_FIRST))

	// Every shutdown frame carries eight data bytes.
	`CANTB_ASSERT_NOW(a_len, m_axis_tvalid, m_axis_tdata[78:75] == cantb_pkg::FRAME_LEN)

endmodule

bind can_receive_timeout_breaker cantb_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
